### hw/rtl/pfa_pkg.sv
// Shared types, codes and widths for the paged frame allocator.
// Used by pfa_div, pfa_ctrl, pfa_datapath and paged_frame_allocator.
package pfa_pkg;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int PID_W    = 4;
  localparam int MEM_W    = 20;
  localparam int FRAME_W  = 10;
  localparam int PGNUM_W  = 4;
  localparam int STATUS_W = 3;
  localparam int PS_W     = 17;

  // Entries reported per table at most
  localparam int MAX_RESULTS = 16;

  // Default geometry
  localparam int NUM_PROCS_DEF      = 16;
  localparam int PAGES_PER_PROC_DEF = 16;
  localparam int FREE_DEPTH_DEF     = 64;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PS_W-1:0] PAGE_SIZE_RST = PS_W'(4096);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_SHOW    = 2'd2;
  localparam logic [OP_W-1:0] OP_SEED    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRAMES = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP_PID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PROC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LIST_FULL = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic                take;
    logic                rd_cnt;
    logic                seed;
    logic                alloc_mark;
    logic                load_bound_pages;
    logic                load_bound_cnt;
    logic                free_rd;
    logic                page_wr;
    logic                page_rd;
    logic                free_wr_page;
    logic                idx_clr;
    logic                idx_inc;
    logic                free_proc;
    logic                emit;
    logic                emit_entry;
    logic                emit_last;
    logic [STATUS_W-1:0] emit_status;
    logic                frame_from_page;
  } pfa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            div_done;
    logic            pid_ok;
    logic            full;
    logic            used;
    logic            cnt_zero;
    logic            pages_zero;
    logic            pages_gt_free;
    logic            pages_gt_max;
    logic            ret_overflow;
    logic            idx_last;
    logic            idx_show;
    logic            idx_show_last;
    logic            out_free;
  } pfa_stat_t;

endpackage

### hw/rtl/pfa_div.sv
// Restoring divider: bytes requested over page size, one quotient bit a cycle.
// Depends on pfa_pkg for operand widths.
module pfa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pfa_pkg::MEM_W-1:0]  dividend,
  input  logic [pfa_pkg::PS_W-1:0]   divisor,
  output logic [pfa_pkg::MEM_W-1:0]  quotient,
  output logic                       done
);

  localparam int CNT_W = $clog2(pfa_pkg::MEM_W);
  localparam int REM_W = pfa_pkg::PS_W + 1;

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [REM_W-1:0]           rem;
  logic [pfa_pkg::MEM_W-1:0]  quo;
  logic [pfa_pkg::PS_W-1:0]   dvs;
  logic [REM_W-1:0]           trial;
  logic                       ge;

  // One shift-subtract step
  assign trial = {rem[pfa_pkg::PS_W-1:0], quo[pfa_pkg::MEM_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(pfa_pkg::MEM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operands; zero page size counts as one
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= (divisor == '0) ? pfa_pkg::PS_W'(1) : divisor;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, dvs}) : trial;
      quo <= {quo[pfa_pkg::MEM_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

### hw/rtl/pfa_ctrl.sv
// Sequencer for the allocator: decodes each item and steps the datapath.
// Depends on pfa_pkg for command/status structs and codes.
module pfa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfa_pkg::pfa_stat_t st,
  output pfa_pkg::pfa_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_READ    = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_POP_RD  = 4'd3;
  localparam logic [3:0] S_POP_WR  = 4'd4;
  localparam logic [3:0] S_PAGE_RD = 4'd5;
  localparam logic [3:0] S_PUSH_WR = 4'd6;
  localparam logic [3:0] S_SHOW_WR = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_cnt = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.out_free && (st.op != pfa_pkg::OP_ALLOC || st.div_done)) begin
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
          if (st.op == pfa_pkg::OP_SEED) begin
            cmd.emit = 1'b1;
            if (st.full) begin
              cmd.emit_status = pfa_pkg::ST_LIST_FULL;
            end else begin
              cmd.seed        = 1'b1;
              cmd.emit_status = pfa_pkg::ST_OK;
            end
          end else if (!st.pid_ok) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = pfa_pkg::ST_NO_PROC;
          end else if (st.op == pfa_pkg::OP_ALLOC) begin
            if (st.pages_gt_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = pfa_pkg::ST_NO_FRAMES;
            end else if (st.used) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = pfa_pkg::ST_DUP_PID;
            end else if (st.pages_gt_max) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = pfa_pkg::ST_TOO_MANY;
            end else begin
              cmd.alloc_mark       = 1'b1;
              cmd.idx_clr          = 1'b1;
              cmd.load_bound_pages = 1'b1;
              if (st.pages_zero) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = pfa_pkg::ST_OK;
              end else begin
                state_next = S_POP_RD;
              end
            end
          end else begin
            // deallocate and show share the empty-table check
            if (st.cnt_zero) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = pfa_pkg::ST_NO_PROC;
            end else if (st.op == pfa_pkg::OP_DEALLOC && st.ret_overflow) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = pfa_pkg::ST_LIST_FULL;
            end else begin
              cmd.idx_clr        = 1'b1;
              cmd.load_bound_cnt = 1'b1;
              state_next         = S_PAGE_RD;
            end
          end
        end
      end
      S_POP_RD: begin
        cmd.free_rd = 1'b1;
        state_next  = S_POP_WR;
      end
      S_POP_WR: begin
        // pages past the reported window are copied without a result
        if (!st.idx_show || st.out_free) begin
          cmd.page_wr     = 1'b1;
          cmd.idx_inc     = 1'b1;
          cmd.emit        = st.idx_show;
          cmd.emit_entry  = 1'b1;
          cmd.emit_last   = st.idx_show_last;
          cmd.emit_status = pfa_pkg::ST_OK;
          state_next      = st.idx_last ? S_IDLE : S_POP_RD;
        end
      end
      S_PAGE_RD: begin
        cmd.page_rd = 1'b1;
        state_next  = (st.op == pfa_pkg::OP_DEALLOC) ? S_PUSH_WR : S_SHOW_WR;
      end
      S_PUSH_WR: begin
        cmd.free_wr_page = 1'b1;
        cmd.idx_inc      = 1'b1;
        state_next       = st.idx_last ? S_FINISH : S_PAGE_RD;
      end
      S_SHOW_WR: begin
        if (st.out_free) begin
          cmd.emit            = 1'b1;
          cmd.emit_entry      = 1'b1;
          cmd.emit_last       = st.idx_show_last;
          cmd.emit_status     = pfa_pkg::ST_OK;
          cmd.frame_from_page = 1'b1;
          cmd.idx_inc         = 1'b1;
          state_next          = st.idx_show_last ? S_IDLE : S_PAGE_RD;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.free_proc   = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = pfa_pkg::ST_OK;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/pfa_datapath.sv
// Storage and arithmetic of the allocator: free-frame FIFO, page tables,
// per-process counts, page-size divider and the result register. Uses pfa_pkg.
module pfa_datapath #(
  parameter int NUM_PROCS      = pfa_pkg::NUM_PROCS_DEF,
  parameter int PAGES_PER_PROC = pfa_pkg::PAGES_PER_PROC_DEF,
  parameter int FREE_DEPTH     = pfa_pkg::FREE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pfa_pkg::pfa_cmd_t             cmd,
  output pfa_pkg::pfa_stat_t            st,
  input  logic [pfa_pkg::PS_W-1:0]      page_size,
  input  logic [pfa_pkg::OP_W-1:0]      op,
  input  logic [pfa_pkg::PID_W-1:0]     pid,
  input  logic [pfa_pkg::MEM_W-1:0]     mem_reqd,
  input  logic [pfa_pkg::FRAME_W-1:0]   frame_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfa_pkg::STATUS_W-1:0]  status,
  output logic                          entry_valid,
  output logic [pfa_pkg::PGNUM_W-1:0]   page_number,
  output logic [pfa_pkg::FRAME_W-1:0]   frame,
  output logic                          last
);

  localparam int PW    = $clog2(NUM_PROCS);
  localparam int FW    = $clog2(FREE_DEPTH);
  localparam int CW    = $clog2(FREE_DEPTH + 1);
  localparam int PCW   = $clog2(PAGES_PER_PROC + 1);
  localparam int PT_N  = NUM_PROCS * PAGES_PER_PROC;
  localparam int AW    = (PT_N > 1) ? $clog2(PT_N) : 1;

  // Latched item
  logic [pfa_pkg::OP_W-1:0]    op_q;
  logic [pfa_pkg::PID_W-1:0]   pid_q;
  logic [pfa_pkg::FRAME_W-1:0] frame_q;
  logic [PW-1:0]               pid_idx;

  // Free-frame FIFO
  logic [pfa_pkg::FRAME_W-1:0] free_mem [FREE_DEPTH];
  logic [FW-1:0]               head;
  logic [FW-1:0]               tail;
  logic [CW-1:0]               free_count;
  logic [pfa_pkg::FRAME_W-1:0] free_q;
  logic                        free_wr;
  logic [pfa_pkg::FRAME_W-1:0] free_wdata;

  // Page tables and per-process counts
  logic [pfa_pkg::FRAME_W-1:0] page_mem [PT_N];
  logic [pfa_pkg::FRAME_W-1:0] page_q;
  logic [AW-1:0]               page_addr;
  logic [PCW-1:0]              cnt_mem [NUM_PROCS];
  logic [PCW-1:0]              cnt_q;
  logic                        used_q;
  logic [NUM_PROCS-1:0]        proc_used;
  logic [PCW-1:0]              cnt_eff;

  // Loop index and bound
  logic [PCW-1:0]              idx;
  logic [PCW-1:0]              bound;
  logic [PCW-1:0]              show_n;

  // Divider
  logic [pfa_pkg::MEM_W-1:0]   pages;
  logic                        div_done;

  pfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.take),
    .dividend (mem_reqd),
    .divisor  (page_size),
    .quotient (pages),
    .done     (div_done)
  );

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q    <= op;
      pid_q   <= pid;
      frame_q <= frame_in;
    end
  end

  assign pid_idx = PW'(pid_q);

  // Count memory and used flags; a slot not in use has no pages
  always_ff @(posedge clk) begin
    if (cmd.rd_cnt) begin
      cnt_q <= cnt_mem[pid_idx];
    end
    if (cmd.alloc_mark) begin
      cnt_mem[pid_idx] <= PCW'(pages);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_used <= '0;
      used_q    <= 1'b0;
    end else begin
      if (cmd.rd_cnt) begin
        used_q <= proc_used[pid_idx];
      end
      if (cmd.alloc_mark) begin
        proc_used[pid_idx] <= 1'b1;
      end else if (cmd.free_proc) begin
        proc_used[pid_idx] <= 1'b0;
      end
    end
  end

  assign cnt_eff = used_q ? cnt_q : '0;

  // FIFO pointers and fill count
  assign free_wr    = cmd.seed || cmd.free_wr_page;
  assign free_wdata = cmd.seed ? frame_q : page_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      free_count <= '0;
    end else begin
      if (free_wr) begin
        tail       <= (tail == FW'(FREE_DEPTH - 1)) ? '0 : tail + 1'b1;
        free_count <= free_count + 1'b1;
      end else if (cmd.free_rd) begin
        head       <= (head == FW'(FREE_DEPTH - 1)) ? '0 : head + 1'b1;
        free_count <= free_count - 1'b1;
      end
    end
  end

  // FIFO storage
  always_ff @(posedge clk) begin
    if (free_wr) begin
      free_mem[tail] <= free_wdata;
    end
    if (cmd.free_rd) begin
      free_q <= free_mem[head];
    end
  end

  // Page table storage
  assign page_addr = AW'(32'(pid_idx) * PAGES_PER_PROC + 32'(idx));

  always_ff @(posedge clk) begin
    if (cmd.page_wr) begin
      page_mem[page_addr] <= free_q;
    end
    if (cmd.page_rd) begin
      page_q <= page_mem[page_addr];
    end
  end

  // Loop index and bound
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.load_bound_pages) begin
      bound <= PCW'(pages);
    end else if (cmd.load_bound_cnt) begin
      bound <= cnt_eff;
    end
  end

  assign show_n = (32'(bound) < pfa_pkg::MAX_RESULTS) ? bound
                                                        : PCW'(pfa_pkg::MAX_RESULTS);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= cmd.emit_status;
      entry_valid <= cmd.emit_entry;
      last        <= cmd.emit_last;
      page_number <= cmd.emit_entry ? pfa_pkg::PGNUM_W'(idx) : '0;
      if (!cmd.emit_entry) begin
        frame <= '0;
      end else if (cmd.frame_from_page) begin
        frame <= page_q;
      end else begin
        frame <= free_q;
      end
    end
  end

  // Status back to the sequencer
  always_comb begin
    st               = '0;
    st.op            = op_q;
    st.div_done      = div_done;
    st.pid_ok        = 32'(pid_q) < NUM_PROCS;
    st.full          = free_count == CW'(FREE_DEPTH);
    st.used          = used_q;
    st.cnt_zero      = cnt_eff == '0;
    st.pages_zero    = pages == '0;
    st.pages_gt_free = 32'(pages) > 32'(free_count);
    st.pages_gt_max  = 32'(pages) > PAGES_PER_PROC;
    st.ret_overflow  = 32'(free_count) + 32'(cnt_eff) > FREE_DEPTH;
    st.idx_last      = 32'(idx) + 1 == 32'(bound);
    st.idx_show      = 32'(idx) < pfa_pkg::MAX_RESULTS;
    st.idx_show_last = 32'(idx) + 1 == 32'(show_n);
    st.out_free      = !out_valid || out_ready;
  end

endmodule

### hw/rtl/paged_frame_allocator.sv
// Top level of the paged frame allocator: configuration register, sequencer
// and datapath. Depends on pfa_pkg, pfa_ctrl, pfa_datapath and pfa_div.
//
// The block holds a FIFO of free frame numbers and a page table per process
// slot, and works on one item at a time. An allocate item first runs a
// divider of bytes requested over the page_size register, one quotient bit
// per cycle, then moves the frames one by one from the FIFO into the page
// table, each move being a registered read followed by a write.
// Deallocate and show also step page by page, each entry a registered read.
// Results leave through an output register, so the next item is taken while
// the last result of the previous one still waits. page_size is at byte
// address 0 of the register port; a page size of zero acts as one.
module paged_frame_allocator #(
  parameter int NUM_PROCS      = pfa_pkg::NUM_PROCS_DEF,
  parameter int PAGES_PER_PROC = pfa_pkg::PAGES_PER_PROC_DEF,
  parameter int FREE_DEPTH     = pfa_pkg::FREE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [pfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [pfa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfa_pkg::OP_W-1:0]      op,
  input  logic [pfa_pkg::PID_W-1:0]     pid,
  input  logic [pfa_pkg::MEM_W-1:0]     mem_reqd,
  input  logic [pfa_pkg::FRAME_W-1:0]   frame_in,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfa_pkg::STATUS_W-1:0]  status,
  output logic                          entry_valid,
  output logic [pfa_pkg::PGNUM_W-1:0]   page_number,
  output logic [pfa_pkg::FRAME_W-1:0]   frame,
  output logic                          last
);

  logic [pfa_pkg::PS_W-1:0] page_size;
  logic                     reg_hit;
  pfa_pkg::pfa_cmd_t        cmd;
  pfa_pkg::pfa_stat_t       st;

  // Register decode: one word at address 0
  assign reg_hit = (paddr[pfa_pkg::PADDR_W-1:2] == '0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? pfa_pkg::PDATA_W'(page_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= pfa_pkg::PAGE_SIZE_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      page_size <= pwdata[pfa_pkg::PS_W-1:0];
    end
  end

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pfa_datapath #(
    .NUM_PROCS      (NUM_PROCS),
    .PAGES_PER_PROC (PAGES_PER_PROC),
    .FREE_DEPTH     (FREE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .page_size   (page_size),
    .op          (op),
    .pid         (pid),
    .mem_reqd    (mem_reqd),
    .frame_in    (frame_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_valid (entry_valid),
    .page_number (page_number),
    .frame       (frame),
    .last        (last)
  );

endmodule

### tb/sv/tb_paged_frame_allocator.sv
// Self-checking testbench for paged_frame_allocator: seeds, allocates, shows and
// frees page tables under random handshake gaps and predicts every result item.
// Depends on pfa_pkg and the paged_frame_allocator RTL only.
`timescale 1ns / 1ps

module tb_paged_frame_allocator;
  import pfa_pkg::*;

  localparam int NPROC          = NUM_PROCS_DEF;
  localparam int PPP            = PAGES_PER_PROC_DEF;
  localparam int FDEPTH         = FREE_DEPTH_DEF;
  localparam int STALL_MAX      = 10;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 50;
  localparam int MAX_REPORTS    = 100;
  localparam logic [PADDR_W-1:0] ADDR_PAGE_SIZE = PADDR_W'(0);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                entry_valid;
    logic [PGNUM_W-1:0]  page_number;
    logic [FRAME_W-1:0]  frame;
    logic                last;
  } table_result_t;

  // DUT ports
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op = OP_SEED;
  logic [PID_W-1:0]    pid = '0;
  logic [MEM_W-1:0]    mem_reqd = '0;
  logic [FRAME_W-1:0]  frame_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                entry_valid;
  logic [PGNUM_W-1:0]  page_number;
  logic [FRAME_W-1:0]  frame;
  logic                last;

  // Shadow copy of the allocator state
  logic [PS_W-1:0]    cur_page_size = PAGE_SIZE_RST;
  logic [FRAME_W-1:0] free_fifo[$];
  logic               slot_used[NPROC];
  int                 slot_pages[NPROC];
  logic [FRAME_W-1:0] slot_frames[NPROC][PPP];
  table_result_t      due_results[$];
  table_result_t      head_result;

  // Handshake pacing
  bit gaps_on = 1'b1;
  int ready_wait = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int err_count = 0;

  paged_frame_allocator u_dut (.*);

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Single result without a table entry
  task automatic push_status(input logic [STATUS_W-1:0] st);
    table_result_t r;
    r.status = st;
    r.entry_valid = 1'b0;
    r.page_number = '0;
    r.frame = '0;
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  // One result per page, capped at MAX_RESULTS
  task automatic push_table(input logic [PID_W-1:0] p);
    table_result_t r;
    int n;
    n = (slot_pages[p] > MAX_RESULTS) ? MAX_RESULTS : slot_pages[p];
    for (int i = 0; i < n; i++) begin
      r.status = ST_OK;
      r.entry_valid = 1'b1;
      r.page_number = PGNUM_W'(i);
      r.frame = slot_frames[p][i];
      r.last = (i == n - 1);
      due_results.push_back(r);
    end
  endtask

  // Apply one accepted request to the shadow state and queue its results
  task automatic book_request(input logic [OP_W-1:0] i_op, input logic [PID_W-1:0] i_pid,
                              input logic [MEM_W-1:0] i_mem,
                              input logic [FRAME_W-1:0] i_frame);
    int ps;
    int pages;
    case (i_op)
      OP_SEED: begin
        if (free_fifo.size() >= FDEPTH) begin
          push_status(ST_LIST_FULL);
        end else begin
          free_fifo.push_back(i_frame);
          push_status(ST_OK);
        end
      end
      OP_ALLOC: begin
        ps = (cur_page_size == 0) ? 1 : int'(cur_page_size);
        pages = int'(i_mem) / ps;
        // check order: frames, duplicate, table size
        if (pages > free_fifo.size()) begin
          push_status(ST_NO_FRAMES);
        end else if (slot_used[i_pid]) begin
          push_status(ST_DUP_PID);
        end else if (pages > PPP) begin
          push_status(ST_TOO_MANY);
        end else begin
          slot_used[i_pid] = 1'b1;
          slot_pages[i_pid] = pages;
          for (int i = 0; i < pages; i++)
            slot_frames[i_pid][i] = free_fifo.pop_front();
          if (pages == 0)
            push_status(ST_OK);
          else
            push_table(i_pid);
        end
      end
      OP_DEALLOC: begin
        pages = slot_pages[i_pid];
        if (pages == 0) begin
          push_status(ST_NO_PROC);
        end else if (free_fifo.size() + pages > FDEPTH) begin
          push_status(ST_LIST_FULL);
        end else begin
          for (int i = 0; i < pages; i++)
            free_fifo.push_back(slot_frames[i_pid][i]);
          slot_used[i_pid] = 1'b0;
          slot_pages[i_pid] = 0;
          push_status(ST_OK);
        end
      end
      default: begin
        if (slot_pages[i_pid] == 0)
          push_status(ST_NO_PROC);
        else
          push_table(i_pid);
      end
    endcase
  endtask

  // Offer one item after a random gap; book it once accepted
  task automatic send_item(input logic [OP_W-1:0] i_op, input logic [PID_W-1:0] i_pid,
                           input logic [MEM_W-1:0] i_mem, input logic [FRAME_W-1:0] i_frame);
    int gap;
    gap = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= i_op;
    pid <= i_pid;
    mem_reqd <= i_mem;
    frame_in <= i_frame;
    do @(posedge clk); while (!in_ready);
    book_request(i_op, i_pid, i_mem, i_frame);
  endtask

  // Wait for every pending result, then let the sequencer go idle
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, then read back
  task automatic write_page_size(input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_PAGE_SIZE;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_page_size = value[PS_W-1:0];
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(cur_page_size))
      report_mismatch($sformatf("page_size read %0h want %0h", prdata, cur_page_size));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random item, mostly well-formed requests sized around the page size
  task automatic send_random_item();
    int pick;
    int pages;
    longint eff;
    longint bytes;
    pick = $urandom_range(0, 99);
    eff = (cur_page_size == 0) ? 1 : longint'(cur_page_size);
    if (pick < 28) begin
      send_item(OP_SEED, $urandom, $urandom, $urandom);
    end else if (pick < 58) begin
      pages = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 9);
      bytes = pages * eff + longint'($urandom_range(0, int'(eff - 1)));
      if (bytes > longint'({MEM_W{1'b1}}))
        bytes = longint'($urandom_range(0, (1 << MEM_W) - 1));
      send_item(OP_ALLOC, $urandom, MEM_W'(bytes), $urandom);
    end else if (pick < 78) begin
      send_item(OP_DEALLOC, $urandom, $urandom, $urandom);
    end else if (pick < 93) begin
      send_item(OP_SHOW, $urandom, $urandom, $urandom);
    end else begin
      send_item($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Empty tables and an empty free list
  task automatic test_empty_state();
    send_item(OP_SHOW, 4'd0, $urandom, $urandom);
    send_item(OP_DEALLOC, 4'd15, $urandom, $urandom);
    send_item(OP_ALLOC, 4'd1, {MEM_W{1'b1}}, $urandom);
    // zero pages still claims the slot, which then can't be freed
    send_item(OP_ALLOC, 4'd3, 20'd4095, $urandom);
    send_item(OP_ALLOC, 4'd3, 20'd0, $urandom);
    send_item(OP_DEALLOC, 4'd3, $urandom, $urandom);
    send_item(OP_SHOW, 4'd3, $urandom, $urandom);
    drain_and_settle();
  endtask

  // Small tables at the reset page size
  task automatic test_small_tables();
    send_item(OP_SEED, $urandom, $urandom, 10'd0);
    send_item(OP_SEED, $urandom, $urandom, 10'd1023);
    send_item(OP_SEED, $urandom, $urandom, 10'h2AA);
    send_item(OP_SEED, $urandom, $urandom, 10'h155);
    send_item(OP_ALLOC, 4'd0, 20'd12287, $urandom);
    // short of frames wins over duplicate pid
    send_item(OP_ALLOC, 4'd0, 20'd12288, $urandom);
    send_item(OP_ALLOC, 4'd0, 20'd4096, $urandom);
    send_item(OP_SHOW, 4'd0, $urandom, $urandom);
    send_item(OP_DEALLOC, 4'd0, $urandom, $urandom);
    send_item(OP_SHOW, 4'd0, $urandom, $urandom);
    drain_and_settle();
  endtask

  // Zero page size acts as one; largest page sizes
  task automatic test_page_size_corners();
    write_page_size(32'd0);
    send_item(OP_ALLOC, 4'd5, 20'd3, $urandom);
    send_item(OP_DEALLOC, 4'd5, $urandom, $urandom);
    drain_and_settle();
    write_page_size(32'd65536);
    send_item(OP_ALLOC, 4'd6, {MEM_W{1'b1}}, $urandom);
    send_item(OP_ALLOC, 4'd6, 20'd262144, $urandom);
    send_item(OP_SHOW, 4'd6, $urandom, $urandom);
    send_item(OP_DEALLOC, 4'd6, $urandom, $urandom);
    drain_and_settle();
    write_page_size(32'h1FFFF);
    send_item(OP_ALLOC, 4'd7, {MEM_W{1'b1}}, $urandom);
    drain_and_settle();
  endtask

  // Fill the free list behind a stalled receiver, then full-table cases
  task automatic test_full_list();
    write_page_size(32'd1);
    gaps_on = 1'b0;
    hold_cycles = HOLD_CYCLES;
    while (free_fifo.size() < FDEPTH)
      send_item(OP_SEED, $urandom, $urandom, $urandom);
    send_item(OP_SEED, $urandom, $urandom, $urandom);
    gaps_on = 1'b1;
    send_item(OP_ALLOC, 4'd7, 20'd17, $urandom);
    send_item(OP_ALLOC, 4'd7, 20'd16, $urandom);
    send_item(OP_ALLOC, 4'd8, 20'd16, $urandom);
    send_item(OP_SHOW, 4'd7, $urandom, $urandom);
    while (free_fifo.size() < FDEPTH)
      send_item(OP_SEED, $urandom, $urandom, $urandom);
    // returning a table into a full list is refused
    send_item(OP_DEALLOC, 4'd7, $urandom, $urandom);
    send_item(OP_ALLOC, 4'd9, 20'd16, $urandom);
    send_item(OP_DEALLOC, 4'd7, $urandom, $urandom);
    drain_and_settle();
  endtask

  // Random traffic across several page sizes, with and without gaps
  task automatic test_random_traffic();
    logic [PDATA_W-1:0] sizes[5];
    sizes[0] = 32'd4096;
    sizes[1] = 32'd1;
    sizes[2] = 32'd65536;
    sizes[3] = PDATA_W'($urandom_range(2, 65535));
    sizes[4] = 32'd0;
    for (int ph = 0; ph < 5; ph++) begin
      write_page_size(sizes[ph]);
      gaps_on = (ph % 2 == 0);
      repeat (PHASE_ITEMS) send_random_item();
      drain_and_settle();
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: long hold when asked, else a random wait after each item
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (ready_wait > 0) begin
      out_ready <= 1'b0;
      ready_wait = ready_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result item with nothing pending");
      end else begin
        head_result = due_results.pop_front();
        if (status !== head_result.status)
          report_mismatch($sformatf("status %0d want %0d", status, head_result.status));
        if (entry_valid !== head_result.entry_valid)
          report_mismatch($sformatf("entry_valid %0b want %0b", entry_valid,
                                    head_result.entry_valid));
        if (page_number !== head_result.page_number)
          report_mismatch($sformatf("page_number %0d want %0d", page_number,
                                    head_result.page_number));
        if (frame !== head_result.frame)
          report_mismatch($sformatf("frame %0d want %0d", frame, head_result.frame));
        if (last !== head_result.last)
          report_mismatch($sformatf("last %0b want %0b", last, head_result.last));
      end
      ready_wait = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_paged_frame_allocator: FAIL");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < NPROC; p++) begin
      slot_used[p] = 1'b0;
      slot_pages[p] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_state();
    test_small_tables();
    test_page_size_corners();
    test_full_list();
    test_random_traffic();

    drain_and_settle();
    if (err_count == 0)
      $display("tb_paged_frame_allocator: PASS");
    else
      $display("tb_paged_frame_allocator: FAIL");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_div.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/pfa_datapath.sv
hw/rtl/paged_frame_allocator.sv
tb/sv/tb_paged_frame_allocator.sv
